// File: rtl/deq_pkg.sv
// Shared constants for the ring-buffer double-ended queue: field widths,
// operation and status codes, and default sizes. No dependencies.
package deq_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 9;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_PUSH_BACK  = 3'd0;
	localparam op_t OP_POP_BACK   = 3'd1;
	localparam op_t OP_PUSH_FRONT = 3'd2;
	localparam op_t OP_POP_FRONT  = 3'd3;
	localparam op_t OP_READ_IDX   = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_FULL  = 2'd3;

endpackage

// File: rtl/deq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing; sized by the parameters handed down from the top level.
module deq_ram #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [DATA_WIDTH-1:0]       wr_data,
	input  logic                        rd_en,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [DATA_WIDTH-1:0]       rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/double_ended_queue_ring.sv
// Top level of the ring-buffer double-ended queue; uses deq_pkg and deq_ram.
// Holds the head pointer, the occupancy count and the result stage.
//
// The queue keeps up to DEPTH words of DATA_WIDTH bits in one simple dual-port
// RAM, addressed as a ring from a head pointer plus an occupancy count. Each
// request carries one operation (push back, pop back, push front, pop front,
// read by index from the front) and yields exactly one result with the word
// popped or read (sign-extended, zero when none), a status (ok, index out of
// range, empty, full) and the count after the operation. Pointers and count
// update at acceptance, where the RAM is also written or read, and the
// result appears the next cycle from the RAM's registered read port, so
// requests stream at one per cycle while the output side keeps taking results.
// A stalled result holds the input side off, as the single result stage is
// then occupied. The RAM needs no clearing after reset: only words written
// by earlier pushes are ever read back. A read that follows a push in the
// next cycle sees the new word, since the write lands at the edge before
// the read.
module double_ended_queue_ring #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [deq_pkg::OP_W-1:0]              op,
	input  logic signed [deq_pkg::VALUE_W-1:0]    value,
	input  logic [deq_pkg::POS_W-1:0]             position,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [deq_pkg::DATA_W-1:0]     data,
	output logic [deq_pkg::STATUS_W-1:0]          status,
	output logic [deq_pkg::COUNT_W-1:0]           count
);

	import deq_pkg::*;

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	// compare width wide enough for both the position field and the count
	localparam int PCW = (CW > POS_W) ? CW : POS_W;
	localparam logic [AW:0]   RING_LEN = (AW+1)'(DEPTH);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	// architectural state
	logic [AW-1:0] head_q;
	logic [CW-1:0] occ_q;

	// result stage
	logic          vld_s1;
	status_t       status_s1;
	logic [CW-1:0] count_s1;
	logic          rsel_s1;

	// next-state and RAM controls
	logic                   acc;
	logic [AW-1:0]          head_n;
	logic [CW-1:0]          occ_n;
	status_t                st_n;
	logic                   rsel_n;
	logic [AW-1:0]          off;
	logic [AW:0]            sum;
	logic [AW-1:0]          tgt;
	logic [AW-1:0]          head_dec;
	logic [AW-1:0]          head_inc;
	logic                   is_full;
	logic                   is_empty;
	logic                   out_of_range;
	logic [CW-1:0]          occ_m1;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [DATA_WIDTH-1:0]  wr_word;
	logic [DATA_WIDTH-1:0]  rd_word;

	// take a new request whenever the result stage is free or draining
	assign in_ready = !vld_s1 || out_ready;
	assign acc      = in_valid && in_ready;

	assign is_full      = (occ_q == FULL_CNT);
	assign is_empty     = (occ_q == '0);
	assign out_of_range = (PCW'(position) >= PCW'(occ_q));
	assign occ_m1       = occ_q - 1'b1;

	// neighbors of the head around the ring
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

	// offset from the head: back slot for pushes, last word for pops,
	// position for reads; only meaningful when the request is in range
	always_comb begin
		unique case (op)
			OP_PUSH_BACK: off = AW'(occ_q);
			OP_POP_BACK:  off = AW'(occ_m1);
			default:      off = AW'(position);
		endcase
	end

	// head + offset stays below twice the depth: one compare and subtract
	assign sum = {1'b0, head_q} + {1'b0, off};
	assign tgt = (sum >= RING_LEN) ? AW'(sum - RING_LEN) : AW'(sum);

	// keep DATA_WIDTH bits of the sign-extended input word
	assign wr_word = DATA_WIDTH'(value);

	always_comb begin
		head_n  = head_q;
		occ_n   = occ_q;
		st_n    = ST_OK;
		rsel_n  = 1'b0;
		wr_en   = 1'b0;
		wr_addr = tgt;
		rd_en   = 1'b0;
		rd_addr = tgt;
		unique case (op)
			OP_PUSH_BACK: begin
				if (is_full) begin
					st_n = ST_FULL;
				end else begin
					wr_en = acc;
					occ_n = occ_q + 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					st_n = ST_EMPTY;
				end else begin
					rd_en  = acc;
					rsel_n = 1'b1;
					occ_n  = occ_m1;
				end
			end
			OP_PUSH_FRONT: begin
				wr_addr = head_dec;
				if (is_full) begin
					st_n = ST_FULL;
				end else begin
					wr_en  = acc;
					head_n = head_dec;
					occ_n  = occ_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				rd_addr = head_q;
				if (is_empty) begin
					st_n = ST_EMPTY;
				end else begin
					rd_en  = acc;
					rsel_n = 1'b1;
					head_n = head_inc;
					occ_n  = occ_m1;
				end
			end
			OP_READ_IDX: begin
				if (out_of_range) begin
					st_n = ST_RANGE;
				end else begin
					rd_en  = acc;
					rsel_n = 1'b1;
				end
			end
			default: begin
				// unused codes: leave everything as it is
			end
		endcase
	end

	// advance pointers and count on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (acc) begin
			head_q <= head_n;
			occ_q  <= occ_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// result payload; held while the output side stalls
	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= st_n;
			count_s1  <= occ_n;
			rsel_s1   <= rsel_n;
		end
	end

	deq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// sign-extend the stored word; drop it when the request read nothing
	assign out_valid = vld_s1;
	assign data      = rsel_s1 ? DATA_W'($signed(rd_word)) : '0;
	assign status    = status_s1;
	assign count     = COUNT_W'(count_s1);

endmodule
